[hw/rtl/glpd_pkg.sv]
// Shared types and constants for the grid local peak detector.
// No dependencies; used by glpd_emit and grid_local_peak_detector.

package glpd_pkg;

	// Field widths fixed by the interface
	localparam int SAMPLE_W = 16;
	localparam int POS_W    = 10;
	localparam int CFG_W    = 11;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

	// Grid size after reset
	localparam int RST_WIDTH  = 5;
	localparam int RST_HEIGHT = 4;

	// Result slots per sample, in raster order
	localparam int NRES      = 3;
	localparam int SLOT_UP   = 0; // sample above the current one
	localparam int SLOT_LEFT = 1; // last row, sample to the left
	localparam int SLOT_SELF = 2; // last sample of the frame

	// One line store entry: sample plus its up/left peak flag
	typedef struct packed {
		logic                       ok;
		logic signed [SAMPLE_W-1:0] value;
	} line_t;

	// One reported peak
	typedef struct packed {
		logic [POS_W-1:0]           row;
		logic [POS_W-1:0]           col;
		logic signed [SAMPLE_W-1:0] value;
	} peak_t;

	// All results caused by one sample
	typedef struct packed {
		logic [NRES-1:0]  hit;
		peak_t [NRES-1:0] item;
	} peak_set_t;

endpackage

[hw/rtl/glpd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.

module glpd_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/glpd_emit.sv]
// Result register: holds the peaks of one sample and sends them one per transfer.
// Depends on glpd_pkg.

module glpd_emit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load_valid,
	input  glpd_pkg::peak_set_t                 load_set,
	output logic                                load_ready,
	output logic                                peak_valid,
	input  logic                                peak_ready,
	output logic [glpd_pkg::POS_W-1:0]          peak_row,
	output logic [glpd_pkg::POS_W-1:0]          peak_col,
	output logic signed [glpd_pkg::SAMPLE_W-1:0] peak_value,
	output logic                                last_of_run
);

	localparam int NRES = glpd_pkg::NRES;

	logic [NRES-1:0]            hit_q;
	glpd_pkg::peak_t [NRES-1:0] item_q;
	logic [NRES-1:0]            low;
	logic [NRES-1:0]            rest;
	glpd_pkg::peak_t            sel;

	// pick the earliest pending result
	always_comb begin
		low  = hit_q & (~hit_q + NRES'(1));
		rest = hit_q & ~low;
		sel  = '0;
		for (int i = 0; i < NRES; i++) begin
			if (low[i]) begin
				sel = item_q[i];
			end
		end
	end

	assign peak_valid  = |hit_q;
	assign peak_row    = sel.row;
	assign peak_col    = sel.col;
	assign peak_value  = sel.value;
	assign last_of_run = (rest == '0);

	// free once the last pending result leaves
	assign load_ready = (hit_q == '0) || (peak_ready && rest == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= '0;
		end else if (load_valid && load_ready) begin
			hit_q <= load_set.hit;
		end else if (peak_valid && peak_ready) begin
			hit_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			item_q <= load_set.item;
		end
	end

endmodule

[hw/rtl/grid_local_peak_detector.sv]
// 4-neighbour local maximum detector on a raster-order sample stream.
// A sample's results pass through the decision stage and then the result register.
// Throughput: one sample per cycle while peak_ready is high; a sample with k > 1 results holds input back.
// The decision needs the line store word one column ahead, read through the registered RAM port.
// Reset: counters to row 0 column 0, grid 5 x 4; the line store is not cleared.
// Depends on glpd_pkg, glpd_ram, glpd_emit.

module grid_local_peak_detector #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// sample input
	input  logic                                 sample_valid,
	output logic                                 sample_ready,
	input  logic signed [glpd_pkg::SAMPLE_W-1:0] sample_value,
	// peak output
	output logic                                 peak_valid,
	input  logic                                 peak_ready,
	output logic [glpd_pkg::POS_W-1:0]           peak_row,
	output logic [glpd_pkg::POS_W-1:0]           peak_col,
	output logic signed [glpd_pkg::SAMPLE_W-1:0] peak_value,
	output logic                                 last_of_run,
	// configuration writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [glpd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [glpd_pkg::CFG_W-1:0]           cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int PW = glpd_pkg::POS_W;
	localparam int SW = glpd_pkg::SAMPLE_W;
	localparam int LW = $bits(glpd_pkg::line_t);
	localparam int RST_W = (glpd_pkg::RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : glpd_pkg::RST_WIDTH;
	localparam int RST_H = (glpd_pkg::RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT :
		glpd_pkg::RST_HEIGHT;

	// size registers hold size minus one
	logic [CW-1:0] w_m1_q;
	logic [RW-1:0] h_m1_q;
	logic [CW-1:0] w_clamp;
	logic [RW-1:0] h_clamp;

	// frame position and left neighbour
	logic [RW-1:0]        row_q;
	logic [CW-1:0]        col_q;
	logic signed [SW-1:0] left_q;
	logic                 left_ok_q;

	// line store access
	logic                 cfg_xfer;
	logic                 in_xfer;
	logic [CW-1:0]        rd_addr;
	logic [LW-1:0]        ram_rdata;
	glpd_pkg::line_t      wr_line;
	glpd_pkg::line_t      mem_rd;
	logic                 fwd_q;
	glpd_pkg::line_t      fwd_line_q;

	// accept-side decode
	logic                 last_col;
	logic                 last_row;
	logic                 up_ok;
	logic                 left_ok;

	// decision stage
	logic                 valid_s1;
	logic signed [SW-1:0] val_s1;
	logic [RW-1:0]        row_s1;
	logic [CW-1:0]        col_s1;
	logic                 has_up_s1;
	logic                 last_row_s1;
	logic                 last_col_s1;
	logic signed [SW-1:0] up_val_s1;
	logic                 up_ok_s1;
	logic signed [SW-1:0] left_val_s1;
	logic                 left_ok_s1;
	logic                 self_ok_s1;
	logic                 emit_ready;
	glpd_pkg::peak_set_t  set_s1;

	assign cfg_ready    = 1'b1;
	assign cfg_xfer     = cfg_valid && cfg_ready;
	assign sample_ready = !valid_s1 || emit_ready;
	assign in_xfer      = sample_valid && sample_ready;

	// size clamping: 0 acts as 1, above the maximum acts as the maximum
	always_comb begin
		if (cfg_data == '0) begin
			w_clamp = '0;
		end else if (32'(cfg_data) > MAX_WIDTH) begin
			w_clamp = CW'(MAX_WIDTH - 1);
		end else begin
			w_clamp = CW'(32'(cfg_data) - 1);
		end
		if (cfg_data == '0) begin
			h_clamp = '0;
		end else if (32'(cfg_data) > MAX_HEIGHT) begin
			h_clamp = RW'(MAX_HEIGHT - 1);
		end else begin
			h_clamp = RW'(32'(cfg_data) - 1);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_m1_q <= CW'(RST_W - 1);
			h_m1_q <= RW'(RST_H - 1);
		end else if (cfg_xfer) begin
			unique case (cfg_index)
				glpd_pkg::REG_GRID_WIDTH:  w_m1_q <= w_clamp;
				glpd_pkg::REG_GRID_HEIGHT: h_m1_q <= h_clamp;
				default: ;
			endcase
		end
	end

	// line store word seen now: last read, or the word written in the same cycle
	assign mem_rd = fwd_q ? fwd_line_q : glpd_pkg::line_t'(ram_rdata);

	// accept side: up/left flag of the new sample, prefetch the next column
	always_comb begin
		last_col = (col_q == w_m1_q);
		last_row = (row_q == h_m1_q);
		up_ok    = (row_q == '0) || (sample_value >= mem_rd.value);
		left_ok  = (col_q == '0) || (sample_value >= left_q);
		wr_line.ok    = up_ok && left_ok;
		wr_line.value = sample_value;
		rd_addr  = last_col ? '0 : col_q + CW'(1);
	end

	glpd_ram #(
		.WIDTH (LW),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (in_xfer),
		.waddr (col_q),
		.wdata (wr_line),
		.re    (in_xfer),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// same-address bypass (one-column grid)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (in_xfer) begin
			fwd_q <= (rd_addr == col_q);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			fwd_line_q <= wr_line;
		end
	end

	// frame position counters; a write to a real register restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			col_q     <= '0;
			left_q    <= '0;
			left_ok_q <= 1'b0;
		end else if (cfg_xfer && (cfg_index == glpd_pkg::REG_GRID_WIDTH ||
				cfg_index == glpd_pkg::REG_GRID_HEIGHT)) begin
			row_q     <= '0;
			col_q     <= '0;
			left_q    <= '0;
			left_ok_q <= 1'b0;
		end else if (in_xfer) begin
			left_ok_q <= wr_line.ok;
			if (last_col) begin
				col_q  <= '0;
				left_q <= '0;
				row_q  <= last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q  <= col_q + CW'(1);
				left_q <= sample_value;
			end
		end
	end

	// decision stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (emit_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// decision stage payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			val_s1      <= sample_value;
			row_s1      <= row_q;
			col_s1      <= col_q;
			has_up_s1   <= (row_q != '0);
			last_row_s1 <= last_row;
			last_col_s1 <= last_col;
			up_val_s1   <= mem_rd.value;
			up_ok_s1    <= mem_rd.ok;
			left_val_s1 <= left_q;
			left_ok_s1  <= left_ok_q;
			self_ok_s1  <= wr_line.ok;
		end
	end

	// peak tests; the prefetched word is the right neighbour of the sample above
	always_comb begin
		set_s1 = '0;

		set_s1.hit[glpd_pkg::SLOT_UP] = has_up_s1 && up_ok_s1 && (up_val_s1 >= val_s1) &&
			(last_col_s1 || (up_val_s1 >= mem_rd.value));
		set_s1.item[glpd_pkg::SLOT_UP].row   = PW'(row_s1 - RW'(1));
		set_s1.item[glpd_pkg::SLOT_UP].col   = PW'(col_s1);
		set_s1.item[glpd_pkg::SLOT_UP].value = up_val_s1;

		set_s1.hit[glpd_pkg::SLOT_LEFT] = last_row_s1 && (col_s1 != '0) && left_ok_s1 &&
			(left_val_s1 >= val_s1);
		set_s1.item[glpd_pkg::SLOT_LEFT].row   = PW'(row_s1);
		set_s1.item[glpd_pkg::SLOT_LEFT].col   = PW'(col_s1 - CW'(1));
		set_s1.item[glpd_pkg::SLOT_LEFT].value = left_val_s1;

		set_s1.hit[glpd_pkg::SLOT_SELF] = last_row_s1 && last_col_s1 && self_ok_s1;
		set_s1.item[glpd_pkg::SLOT_SELF].row   = PW'(row_s1);
		set_s1.item[glpd_pkg::SLOT_SELF].col   = PW'(col_s1);
		set_s1.item[glpd_pkg::SLOT_SELF].value = val_s1;
	end

	glpd_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.load_valid  (valid_s1),
		.load_set    (set_s1),
		.load_ready  (emit_ready),
		.peak_valid  (peak_valid),
		.peak_ready  (peak_ready),
		.peak_row    (peak_row),
		.peak_col    (peak_col),
		.peak_value  (peak_value),
		.last_of_run (last_of_run)
	);

endmodule
